/* src/ctsb_pkg.sv */
// ----------------------------------------------------------------------------
// ctsb_pkg: shared types and decode tables for the ctime string parser
// Holds the parser state record, the field length table and the name decoders.
// ----------------------------------------------------------------------------
package ctsb_pkg;

   localparam int unsigned NumFields   = 7;
   localparam logic [4:0]  MaxPosition = 5'd24;
   localparam logic [2:0]  LastField   = 3'd7;
   localparam logic [7:0]  CharSpace   = 8'h20;
   localparam logic [7:0]  CharColon   = 8'h3a;
   localparam logic [7:0]  CharNul     = 8'h00;
   localparam logic [3:0]  NibbleMask  = 4'hf;

   // field codes
   localparam logic [2:0] FldWeekday = 3'd0;
   localparam logic [2:0] FldMonth   = 3'd1;
   localparam logic [2:0] FldDay     = 3'd2;
   localparam logic [2:0] FldHour    = 3'd3;
   localparam logic [2:0] FldMinute  = 3'd4;
   localparam logic [2:0] FldSecond  = 3'd5;
   localparam logic [2:0] FldYear    = 3'd6;

   typedef struct packed {
      logic [2:0]       field_index;
      logic [2:0]       chars_in_field;
      logic [4:0]       char_position;
      logic [3:0][7:0]  field_chars;
      logic [2:0]       weekday;
      logic [3:0]       month;
      logic [4:0][7:0]  bcd;        // day, hour, minute, second, year
   } ctsb_state_type;

   localparam ctsb_state_type StateReset = '0;

   // characters per field, 0 beyond the last field
   function automatic logic [2:0] field_len(input logic [2:0] fld);
      logic [2:0] len;
      case (fld)
         FldWeekday, FldMonth:                       len = 3'd3;
         FldDay, FldHour, FldMinute, FldSecond:      len = 3'd2;
         FldYear:                                    len = 3'd4;
         default:                                    len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [2:0] day_code(input logic [23:0] name);
      logic [2:0] code;
      case (name)
         "Mon":   code = 3'd1;
         "Tue":   code = 3'd2;
         "Wed":   code = 3'd3;
         "Thu":   code = 3'd4;
         "Fri":   code = 3'd5;
         "Sat":   code = 3'd6;
         "Sun":   code = 3'd7;
         default: code = 3'd0;
      endcase
      return code;
   endfunction

   function automatic logic [3:0] month_code(input logic [23:0] name);
      logic [3:0] code;
      case (name)
         "Jan":   code = 4'd1;
         "Feb":   code = 4'd2;
         "Mar":   code = 4'd3;
         "Apr":   code = 4'd4;
         "May":   code = 4'd5;
         "Jun":   code = 4'd6;
         "Jul":   code = 4'd7;
         "Aug":   code = 4'd8;
         "Sep":   code = 4'd9;
         "Oct":   code = 4'd10;
         "Nov":   code = 4'd11;
         "Dec":   code = 4'd12;
         default: code = 4'd0;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] pack_bcd(input logic [7:0] hi, input logic [7:0] lo);
      return {hi[3:0] & NibbleMask, lo[3:0] & NibbleMask};
   endfunction

endpackage

/* src/ctsb_char_step.sv */
// ----------------------------------------------------------------------------
// ctsb_char_step: next parser state for one character
// Counts position, advances fields on separators, collects and decodes fields.
// ----------------------------------------------------------------------------
module ctsb_char_step import ctsb_pkg::*; (
   input  ctsb_state_type cur,
   input  logic [7:0]     char_code,
   output ctsb_state_type nxt
);

   logic [3:0][7:0] chars;
   logic [2:0]      count;
   logic [2:0]      bcd_slot;

   always_comb begin
      nxt      = cur;
      chars    = cur.field_chars;
      count    = cur.chars_in_field + 3'd1;
      bcd_slot = cur.field_index - FldDay;
      chars[cur.chars_in_field[1:0]] = char_code;

      if (cur.char_position >= MaxPosition) begin
         nxt = cur;
      end else if (char_code == CharNul) begin
         nxt.char_position = MaxPosition;
      end else begin
         nxt.char_position = cur.char_position + 5'd1;
         if (cur.chars_in_field == 3'd0 &&
             (char_code == CharSpace || char_code == CharColon)) begin
            if (cur.field_index < LastField) begin
               nxt.field_index = cur.field_index + 3'd1;
            end
         end else if (cur.field_index != LastField) begin
            if (count >= field_len(cur.field_index)) begin
               // field complete: decode from collected chars plus this one
               case (cur.field_index)
                  FldWeekday: nxt.weekday = day_code({chars[0], chars[1], chars[2]});
                  FldMonth:   nxt.month   = month_code({chars[0], chars[1], chars[2]});
                  FldDay, FldHour, FldMinute, FldSecond: begin
                     nxt.bcd[bcd_slot] = pack_bcd(chars[0], chars[1]);
                  end
                  FldYear:    nxt.bcd[4] = pack_bcd(chars[2], chars[3]);
                  default:    nxt.bcd    = cur.bcd;
               endcase
               nxt.chars_in_field = 3'd0;
               nxt.field_chars    = '0;
            end else begin
               nxt.chars_in_field = count;
               nxt.field_chars    = chars;
            end
         end
      end
   end

endmodule

/* src/ctime_string_to_bcd_parser.sv */
// ----------------------------------------------------------------------------
// ctime_string_to_bcd_parser: ctime date string to weekday/month/BCD fields
// Path: a character is taken into the input register, its result into the result register.
// Throughput: one character per cycle, except that a last character stalls while
//   the output still holds an unaccepted result; ctsb_char_step runs one pass per cycle.
// Reset: synchronous, active high; clears parser state and both valid flags.
// The string state returns to reset after the character carrying tlast.
// ----------------------------------------------------------------------------
module ctime_string_to_bcd_parser import ctsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_code
   input  logic        req_tlast,    // last_char
   // decoded results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata     // [2:0] weekday, [6:3] month, [14:7] day_bcd,
                                     // [22:15] hour_bcd, [30:23] minute_bcd,
                                     // [38:31] second_bcd, [46:39] year_bcd, [47] 0
);

   // input register
   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_char_ff;
   logic           in_last_ff;

   // parser state
   ctsb_state_type state_ff, state_in, step_nxt;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [47:0]    rsp_data_ff;

   logic           stall;      // a result is due but the output is still full
   logic           proc_go;    // character in the input register is consumed

   assign stall      = in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready;
   assign proc_go    = in_valid_ff && !stall;
   assign req_tready = !in_valid_ff || !stall;

   ctsb_char_step u_step (
      .cur       (state_ff),
      .char_code (in_char_ff),
      .nxt       (step_nxt)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end

      state_in = state_ff;
      if (proc_go) begin
         // the string ends: report then drop back to reset state
         state_in = in_last_ff ? StateReset : step_nxt;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (proc_go && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= StateReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (proc_go && in_last_ff) begin
         rsp_data_ff <= {1'b0, step_nxt.bcd[4], step_nxt.bcd[3], step_nxt.bcd[2],
                         step_nxt.bcd[1], step_nxt.bcd[0], step_nxt.month,
                         step_nxt.weekday};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a consumed last character always produces a result next cycle
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      proc_go && in_last_ff |=> rsp_valid_ff)
      else $error("last character did not produce a result");

   // state is cleared after the last character of a string
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      proc_go && in_last_ff |=> state_ff.char_position == 5'd0 &&
                                state_ff.field_index == 3'd0)
      else $error("parser state not cleared after string end");

   // position saturates at the limit
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.char_position <= MaxPosition)
      else $error("character position beyond limit");

   // an open field never holds a full year's worth of characters
   a_field_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.chars_in_field < 3'd4)
      else $error("field character count overflow");

endmodule

/* bench/ctsb_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctsb_checker: result checker for the ctime string parser
// Watches both streams, runs its own copy of the parsing rules on every
// accepted character and compares each decoded result with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module ctsb_checker import ctsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   output int          fail_count,
   output int          open_count,
   output int          result_count
);

   // weekday in the low bits, as on rsp_tdata
   typedef struct packed {
      logic [7:0] year;
      logic [7:0] second;
      logic [7:0] minute;
      logic [7:0] hour;
      logic [7:0] day;
      logic [3:0] month;
      logic [2:0] weekday;
   } date_fields_type;

   // name n+1 sits at bits [24*n +: 24]
   localparam logic [287:0] DayNames   = "SunSatFriThuWedTueMon";
   localparam logic [287:0] MonthNames = "DecNovOctSepAugJulJunMayAprMarFebJan";
   localparam logic [20:0]  FieldLens  = {3'd4, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3};

   logic [2:0]      cur_field;
   logic [2:0]      field_fill;
   logic [4:0]      str_pos;
   logic [3:0][7:0] field_bytes;
   date_fields_type parsed;
   date_fields_type expected_dates[$];

   function automatic logic [3:0] name_number(input logic [23:0] nm,
                                              input logic [287:0] names,
                                              input int count);
      int n;
      for (n = 0; n < count; n++)
         if (names[24*n +: 24] == nm) return 4'(n + 1);
      return 4'd0;
   endfunction

   task clear_string();
      cur_field   = '0;
      field_fill  = '0;
      str_pos     = '0;
      field_bytes = '0;
      parsed      = '0;
   endtask

   task close_field();
      logic [23:0] nm;
      nm = {field_bytes[0], field_bytes[1], field_bytes[2]};
      case (cur_field)
         FldWeekday: parsed.weekday = 3'(name_number(nm, DayNames, 7));
         FldMonth:   parsed.month   = name_number(nm, MonthNames, 12);
         FldDay:     parsed.day     = {field_bytes[0][3:0], field_bytes[1][3:0]};
         FldHour:    parsed.hour    = {field_bytes[0][3:0], field_bytes[1][3:0]};
         FldMinute:  parsed.minute  = {field_bytes[0][3:0], field_bytes[1][3:0]};
         FldSecond:  parsed.second  = {field_bytes[0][3:0], field_bytes[1][3:0]};
         FldYear:    parsed.year    = {field_bytes[2][3:0], field_bytes[3][3:0]};
         default: ;
      endcase
   endtask

   task absorb_char(input logic [7:0] ch);
      if (str_pos >= MaxPosition) return;
      if (ch == CharNul) begin
         str_pos = MaxPosition;
         return;
      end
      str_pos++;
      // separators only count between fields
      if (field_fill == 0 && (ch == CharSpace || ch == CharColon)) begin
         if (cur_field < LastField) cur_field++;
         return;
      end
      if (cur_field == LastField) return;
      field_bytes[field_fill[1:0]] = ch;
      field_fill++;
      if (field_fill >= FieldLens[3*cur_field +: 3]) begin
         close_field();
         field_fill  = '0;
         field_bytes = '0;
      end
   endtask

   task check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   initial clear_string();

   always @(posedge clock) begin
      date_fields_type got;
      date_fields_type want;
      if (reset) begin
         clear_string();
         expected_dates.delete();
      end else begin
         // result first: a character never yields a result in its own cycle
         if (rsp_tvalid && rsp_tready) begin
            got = date_fields_type'(rsp_tdata[46:0]);
            result_count++;
            check_field("pad", 8'h00, {7'd0, rsp_tdata[47]});
            if (expected_dates.size() == 0) begin
               $error("result with nothing outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_dates.pop_front();
               check_field("weekday", want.weekday, got.weekday);
               check_field("month", want.month, got.month);
               check_field("day_bcd", want.day, got.day);
               check_field("hour_bcd", want.hour, got.hour);
               check_field("minute_bcd", want.minute, got.minute);
               check_field("second_bcd", want.second, got.second);
               check_field("year_bcd", want.year, got.year);
            end
         end
         if (req_tvalid && req_tready) begin
            absorb_char(req_tdata);
            if (req_tlast) begin
               expected_dates.push_back(parsed);
               clear_string();
            end
         end
      end
      open_count = expected_dates.size();
   end

endmodule

/* bench/ctime_string_to_bcd_parser_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctime_string_to_bcd_parser_tb: top level bench for the ctime string parser
// Feeds date strings one character per transfer: a few hand-made strings,
// then mostly well-formed dates with random content, mangled dates, separator
// runs and raw byte noise. Both streams idle at random; a checker beside the
// block predicts and compares every decoded result.
// ----------------------------------------------------------------------------
module ctime_string_to_bcd_parser_tb import ctsb_pkg::*; ;

   localparam int TargetChars   = 1800;
   localparam int QuietFrom     = 1550;  // no idling past this many characters
   localparam int WatchdogLimit = 2000;  // cycles without any transfer
   localparam int DrainCycles   = 8;     // idle time after the last result, to catch stray results

   localparam logic [167:0] DayNames   = "SunSatFriThuWedTueMon";
   localparam logic [287:0] MonthNames = "DecNovOctSepAugJulJunMayAprMarFebJan";

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // [7:0] char_code
   logic        req_tlast;     // last_char
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;     // [2:0] weekday, [6:3] month, [14:7] day_bcd,
                               // [22:15] hour_bcd, [30:23] minute_bcd,
                               // [38:31] second_bcd, [46:39] year_bcd, [47] 0

   int fail_count;
   int open_count;
   int result_count;

   int gap_pct = 20;           // shared idle chance, percent for sends, half that for results
   int chars_sent;
   int strings_sent;
   int idle_cycles;
   logic [7:0] line_q[$];      // string being assembled

   always #5 clock = ~clock;

   ctime_string_to_bcd_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ctsb_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .open_count   (open_count),
      .result_count (result_count)
   );

   // ------------------------------------------------------------------
   // Watchdog: a stretch of WatchdogLimit without a transfer on either side is a hang.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result side backpressure: random stall bursts.
   // ------------------------------------------------------------------
   initial begin
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && $urandom_range(0, 199) < gap_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Character sender. Valid stays high across back-to-back transfers and
   // only drops for an idle burst, so it never gets two updates in a step.
   // ------------------------------------------------------------------
   task send_char(input logic [7:0] ch, input logic is_last);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
   endtask

   // whole string, tlast on the final character
   task send_line();
      int i;
      for (i = 0; i < line_q.size(); i++)
         send_char(line_q[i], i == line_q.size() - 1);
      strings_sent++;
      line_q.delete();
   endtask

   // hold off the sender until every predicted result is back
   task wait_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   task put_text(input logic [23:0] txt, input int count);
      int i;
      for (i = count - 1; i >= 0; i--) line_q.push_back(txt[8*i +: 8]);
   endtask

   // field separator: usually the canonical one, sometimes swapped,
   // doubled or dropped
   task put_sep(input logic [7:0] sep);
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)       line_q.push_back(sep == CharSpace ? CharColon : CharSpace);
      else if (r < 13) begin
         line_q.push_back(sep);
         line_q.push_back(sep);
      end else if (r >= 18) line_q.push_back(sep);
   endtask

   // 3-letter name; occasionally lower case or junk
   task put_name(input logic [287:0] names, input int count);
      logic [23:0] nm;
      int r;
      nm = names[24*$urandom_range(0, count - 1) +: 24];
      r = $urandom_range(0, 99);
      if (r < 5)       nm = nm | 24'h202020;
      else if (r < 12) nm = {8'($urandom), 8'($urandom), 8'($urandom)};
      put_text(nm, 3);
   endtask

   // digit field; rarely a raw byte so the high nibbles get exercised
   task put_digits(input int count);
      int i;
      for (i = 0; i < count; i++)
         if ($urandom_range(0, 19) == 0) line_q.push_back(8'($urandom));
         else line_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
   endtask

   // "Www Mmm DD HH:MM:SS YYYY" with random content and optional damage
   task build_date();
      int r;
      int i;
      put_name({120'd0, DayNames}, 7);
      put_sep(CharSpace);
      put_name(MonthNames, 12);
      put_sep(CharSpace);
      put_digits(2);
      put_sep(CharSpace);
      put_digits(2);
      put_sep(CharColon);
      put_digits(2);
      put_sep(CharColon);
      put_digits(2);
      put_sep(CharSpace);
      put_digits(4);
      r = $urandom_range(0, 99);
      if (r < 10) begin
         // truncated: string cut short at a random point
         while (line_q.size() > $urandom_range(1, 23)) void'(line_q.pop_back());
      end else if (r < 22) begin
         // overlong: tail beyond position 24 is ignored
         for (i = $urandom_range(1, 8); i > 0; i--) line_q.push_back(8'($urandom));
      end else if (r < 28) begin
         line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom);
      end else if (r < 32) begin
         // embedded NUL ends the string early
         line_q[$urandom_range(0, line_q.size() - 1)] = CharNul;
      end
   endtask

   // separator-heavy runs: too many fields, leading separators
   task build_separators();
      int i;
      for (i = $urandom_range(1, 30); i > 0; i--)
         case ($urandom_range(0, 4))
            0:       line_q.push_back(CharSpace);
            1:       line_q.push_back(CharColon);
            default: line_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
         endcase
   endtask

   // raw bytes over the full range
   task build_noise();
      int i;
      for (i = $urandom_range(1, 30); i > 0; i--)
         line_q.push_back($urandom_range(0, 29) == 0 ? CharNul : 8'($urandom_range(1, 255)));
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int r;
      logic mid_pause_done;
      mid_pause_done = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: all-ones byte alone, highest names, fields run together,
      // NUL cutting a string, leading separators moving to the day field
      line_q.push_back(8'hff);
      send_line();
      put_text("Sun", 3);
      line_q.push_back(CharSpace);
      put_text("Dec", 3);
      send_line();
      put_text("Mon", 3);
      put_text("Jan", 3);
      send_line();
      put_text("Tue", 3);
      line_q.push_back(CharNul);
      line_q.push_back(8'h78);
      send_line();
      line_q.push_back(CharColon);
      line_q.push_back(CharSpace);
      put_text("09", 2);
      send_line();
      wait_results();

      // random part
      while (chars_sent < TargetChars) begin
         if (chars_sent >= QuietFrom) begin
            gap_pct = 0;
         end else if ($urandom_range(0, 9) == 0) begin
            r = $urandom_range(0, 2);
            gap_pct = (r == 0) ? 0 : (r == 1) ? 15 : 50;
         end
         if (!mid_pause_done && chars_sent >= TargetChars / 2) begin
            wait_results();
            mid_pause_done = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 70)      build_date();
         else if (r < 85) build_separators();
         else             build_noise();
         send_line();
      end

      // drain and watch for stray results
      wait_results();
      repeat (DrainCycles) @(posedge clock);

      $display("summary: %0d strings, %0d characters sent, %0d decoded results checked",
               strings_sent, chars_sent, result_count);
      $display("summary: dates with random and damaged content, separator runs, raw bytes");
      if (fail_count == 0 && open_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/ctsb_pkg.sv
src/ctsb_char_step.sv
src/ctime_string_to_bcd_parser.sv
bench/ctsb_checker.sv
bench/ctime_string_to_bcd_parser_tb.sv
